// ===== src/hsc_pkg.sv =====
// Shared types and constants for the Hangul syllable compose/decompose unit.
// No dependencies; imported by every module of the unit.
package hsc_pkg;

	localparam int CP_W   = 21;
	localparam int SIDX_W = 14;  // syllable index, below 11172
	localparam int QT_W   = 9;   // syllable index / 28, below 399
	localparam int JIDX_W = 5;   // L, V or T index

	// operation codes
	localparam logic OP_DECOMPOSE = 1'b0;
	localparam logic OP_COMPOSE   = 1'b1;

	// Hangul arithmetic constants
	localparam logic [CP_W-1:0] S_BASE = 21'h00AC00;
	localparam logic [CP_W-1:0] L_BASE = 21'h001100;
	localparam logic [CP_W-1:0] V_BASE = 21'h001161;
	localparam logic [CP_W-1:0] T_BASE = 21'h0011A7;
	localparam int L_COUNT = 19;
	localparam int V_COUNT = 21;
	localparam int T_COUNT = 28;
	localparam int N_COUNT = V_COUNT * T_COUNT;
	localparam int S_COUNT = L_COUNT * N_COUNT;

	// reciprocals: x / 28 = (x * RECIP_T) >> 20, x / 588 = (x * RECIP_N) >> 24,
	// exact for every syllable index
	localparam int RECIP_T_SH = 20;
	localparam int RECIP_N_SH = 24;
	localparam int RECIP_T    = (1 << RECIP_T_SH) / T_COUNT + 1;
	localparam int RECIP_N    = (1 << RECIP_N_SH) / N_COUNT + 1;
	localparam int PROD_W     = 30;

	// one decoded item: up to three results
	typedef struct packed {
		logic [1:0]      cnt;  // number of results, 1 to 3
		logic            hit;
		logic [CP_W-1:0] cp0;
		logic [CP_W-1:0] cp1;
		logic [CP_W-1:0] cp2;
	} hsc_entry_t;

endpackage

// ===== src/hsc_front.sv =====
// Front end: accepts items, classifies code points and works out jamo indices.
// Two pipeline stages; depends on hsc_pkg.
module hsc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      op,
	input  logic [hsc_pkg::CP_W-1:0]  first_code,
	input  logic [hsc_pkg::CP_W-1:0]  second_code,
	input  logic                      q_full,
	output logic                      q_push,
	output hsc_pkg::hsc_entry_t       q_data
);
	import hsc_pkg::*;

	logic              v_s1, v_s2;
	logic              op_s1, op_s2;
	logic [CP_W-1:0]   a_s1, a_s2;
	logic [CP_W-1:0]   b_s1;
	logic              rdy1, rdy2;

	logic [CP_W-1:0]   a_off, la_off, vb_off, tb_off;
	logic              a_is_s, a_is_l, b_is_v, b_is_t;
	logic [SIDX_W-1:0] s_idx, lv_idx;
	logic [PROD_W-1:0] prod_q, prod_l;
	logic [CP_W-1:0]   lv;

	logic              a_is_s_s2, a_is_l_s2, b_is_v_s2, b_is_t_s2;
	logic [SIDX_W-1:0] s_idx_s2;
	logic [QT_W-1:0]   q_s2;
	logic [JIDX_W-1:0] l_s2, tb_s2;
	logic [CP_W-1:0]   lv_s2;

	logic [JIDX_W-1:0] t_idx, v_idx;
	logic [CP_W-1:0]   lvt;

	// stall chain from the queue back to the input
	assign rdy2   = !v_s2 || !q_full;
	assign rdy1   = !v_s1 || rdy2;
	assign full   = !rdy1;
	assign q_push = v_s2 && !q_full;

	// advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= push;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	// stage 1 payload: capture the item
	always_ff @(posedge clk) begin
		if (rdy1) begin
			op_s1 <= op;
			a_s1  <= first_code;
			b_s1  <= second_code;
		end
	end

	// classify and start the divisions by reciprocal
	always_comb begin
		a_off  = a_s1 - S_BASE;
		la_off = a_s1 - L_BASE;
		vb_off = b_s1 - V_BASE;
		tb_off = b_s1 - T_BASE;
		a_is_s = (a_s1 >= S_BASE) && (a_off < CP_W'(S_COUNT));
		a_is_l = (a_s1 >= L_BASE) && (la_off < CP_W'(L_COUNT));
		b_is_v = (b_s1 >= V_BASE) && (vb_off < CP_W'(V_COUNT));
		b_is_t = (b_s1 > T_BASE) && (tb_off < CP_W'(T_COUNT));
		s_idx  = a_off[SIDX_W-1:0];
		prod_q = PROD_W'(s_idx) * PROD_W'(RECIP_T);
		prod_l = PROD_W'(s_idx) * PROD_W'(RECIP_N);
		lv_idx = SIDX_W'(la_off[JIDX_W-1:0]) * SIDX_W'(V_COUNT)
			+ SIDX_W'(vb_off[JIDX_W-1:0]);
		lv     = S_BASE + CP_W'(lv_idx * SIDX_W'(T_COUNT));
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (rdy2) begin
			op_s2     <= op_s1;
			a_s2      <= a_s1;
			a_is_s_s2 <= a_is_s;
			a_is_l_s2 <= a_is_l;
			b_is_v_s2 <= b_is_v;
			b_is_t_s2 <= b_is_t;
			s_idx_s2  <= s_idx;
			q_s2      <= prod_q[RECIP_T_SH +: QT_W];
			l_s2      <= prod_l[RECIP_N_SH +: JIDX_W];
			tb_s2     <= tb_off[JIDX_W-1:0];
			lv_s2     <= lv;
		end
	end

	// finish the remainders and build the queue entry
	always_comb begin
		t_idx = JIDX_W'(s_idx_s2 - SIDX_W'(SIDX_W'(q_s2) * SIDX_W'(T_COUNT)));
		v_idx = JIDX_W'(q_s2 - QT_W'(QT_W'(l_s2) * QT_W'(V_COUNT)));
		lvt   = a_s2 + CP_W'(tb_s2);

		q_data.cnt = 2'd1;
		q_data.hit = 1'b0;
		q_data.cp0 = a_s2;
		q_data.cp1 = V_BASE + CP_W'(v_idx);
		q_data.cp2 = T_BASE + CP_W'(t_idx);
		unique case (op_s2)
			OP_DECOMPOSE: begin
				if (a_is_s_s2) begin
					q_data.cnt = (t_idx == '0) ? 2'd2 : 2'd3;
					q_data.hit = 1'b1;
					q_data.cp0 = L_BASE + CP_W'(l_s2);
				end
			end
			OP_COMPOSE: begin
				priority if (a_is_l_s2 && b_is_v_s2) begin
					q_data.hit = 1'b1;
					q_data.cp0 = lv_s2;
				end else if (a_is_s_s2 && (t_idx == '0) && b_is_t_s2) begin
					q_data.hit = 1'b1;
					q_data.cp0 = lvt;
				end else begin
					q_data.hit = 1'b0;
				end
			end
			default: q_data.hit = 1'b0;
		endcase
	end

endmodule

// ===== src/hsc_queue.sv =====
// Short FIFO of decoded items between the front and back ends.
// Depends on hsc_pkg for the entry type.
module hsc_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hsc_pkg::hsc_entry_t wdata,
	output logic                full,
	input  logic                pop,
	output hsc_pkg::hsc_entry_t rdata,
	output logic                empty
);
	import hsc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hsc_entry_t      mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// store entries
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// ===== src/hsc_back.sv =====
// Back end: holds one decoded item and emits its results one per cycle while pop is held.
// Depends on hsc_pkg for the entry type.
module hsc_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  hsc_pkg::hsc_entry_t       q_data,
	output logic                      q_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic [hsc_pkg::CP_W-1:0]  code_point,
	output logic                      is_last,
	output logic                      hit
);
	import hsc_pkg::*;

	hsc_entry_t ent_q;
	logic       bv_q;
	logic [1:0] idx_q;
	logic       take, load;

	assign take    = pop && bv_q;
	assign is_last = (2'(idx_q + 2'd1) == ent_q.cnt);
	assign load    = !bv_q || (take && is_last);
	assign q_pop   = load && !q_empty;
	assign empty   = !bv_q;
	assign hit     = ent_q.hit;

	// select the current result
	always_comb begin
		unique case (idx_q)
			2'd0:    code_point = ent_q.cp0;
			2'd1:    code_point = ent_q.cp1;
			default: code_point = ent_q.cp2;
		endcase
	end

	// advance through the results, reload at the end of an item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q  <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			bv_q  <= !q_empty;
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// hold the item payload
	always_ff @(posedge clk) begin
		if (q_pop) ent_q <= q_data;
	end

endmodule

// ===== src/hangul_syllable_compose_decompose_unit.sv =====
// Hangul syllable compose/decompose unit, top level.
// An accepted item passes the front-end stages, the queue and the output register.
// Throughput: one item per cycle for single-result items while pop is held; a
// decomposed syllable gives two or three results, one per cycle on the result port.
// Reset (arst_n low) empties the pipeline, queue and output stage at once.
module hangul_syllable_compose_decompose_unit #(
	parameter int DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      op,
	input  logic [hsc_pkg::CP_W-1:0]  first_code,
	input  logic [hsc_pkg::CP_W-1:0]  second_code,
	output logic                      empty,
	input  logic                      pop,
	output logic [hsc_pkg::CP_W-1:0]  code_point,
	output logic                      is_last,
	output logic                      hit
);
	import hsc_pkg::*;

	hsc_entry_t f_data, b_data;
	logic       f_push, q_full, q_pop, q_empty;

	hsc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.first_code  (first_code),
		.second_code (second_code),
		.q_full      (q_full),
		.q_push      (f_push),
		.q_data      (f_data)
	);

	hsc_queue #(.DEPTH(DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_data),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (b_data),
		.empty  (q_empty)
	);

	hsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (b_data),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.code_point (code_point),
		.is_last    (is_last),
		.hit        (hit)
	);

endmodule

// ===== src/hsc_checker.sv =====
// Port-level checks for the Hangul syllable compose/decompose unit.
// Bound to the top level; depends on hsc_pkg for the code point width.
module hsc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      empty,
	input logic                      pop,
	input logic [hsc_pkg::CP_W-1:0]  code_point,
	input logic                      is_last,
	input logic                      hit
);
	import hsc_pkg::*;

	// no result shows once reset has been seen at an edge
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result visible during reset");

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(code_point) && $stable(is_last)
			&& $stable(hit))
		else $error("stalled result changed");

	// a miss is always a single, final result
	a_miss_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !hit |-> is_last)
		else $error("missed item with more than one result");

	// the rest of a split syllable follows at once
	a_split_cont: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !is_last |=> !empty && hit)
		else $error("split syllable lost its next result");

endmodule

bind hangul_syllable_compose_decompose_unit hsc_checker u_hsc_checker (.*);
